// ----- design/u8vc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8vc_pkg
// Shared types, constants and the byte classifier of the UTF-8 validator and
// character counter.
// ----------------------------------------------------------------------------
package u8vc_pkg;

   localparam int unsigned QueueDepthDefault = 4;
   localparam int unsigned CountWidth        = 32;
   localparam int unsigned PendWidth         = 3;
   localparam logic [CountWidth-1:0] CountMax = '1;

   // byte classes
   localparam logic [1:0] CLS_ASCII = 2'd0;
   localparam logic [1:0] CLS_LEAD  = 2'd1;
   localparam logic [1:0] CLS_CONT  = 2'd2;
   localparam logic [1:0] CLS_BAD   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } u8vc_req_type;

   typedef struct packed {
      logic                  status;
      logic [CountWidth-1:0] char_count;
      logic [PendWidth-1:0]  missing_bytes;
   } u8vc_rsp_type;

   typedef struct packed {
      logic [1:0]           cls;
      logic [PendWidth-1:0] pend_load;
      logic                 final_byte;
   } u8vc_entry_type;

   function automatic u8vc_entry_type u8vc_classify(input u8vc_req_type item);
      u8vc_entry_type e;
      e.final_byte = item.final_byte;
      e.pend_load  = '0;
      case (item.data_byte) inside
         8'b0???????: e.cls = CLS_ASCII;
         8'b10??????: e.cls = CLS_CONT;
         8'b110?????: begin
            e.cls       = CLS_LEAD;
            e.pend_load = PendWidth'(1);
         end
         8'b1110????: begin
            e.cls       = CLS_LEAD;
            e.pend_load = PendWidth'(2);
         end
         8'b11110???: begin
            e.cls       = CLS_LEAD;
            e.pend_load = PendWidth'(3);
         end
         8'b111110??: begin
            e.cls       = CLS_LEAD;
            e.pend_load = PendWidth'(4);
         end
         8'b1111110?: begin
            e.cls       = CLS_LEAD;
            e.pend_load = PendWidth'(5);
         end
         default: e.cls = CLS_BAD;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

// ----- design/u8vc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8vc_front
// Input side: accepts bytes while the queue has room and classifies each.
// ----------------------------------------------------------------------------
module u8vc_front
   import u8vc_pkg::*;
(
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire u8vc_req_type   req_item,
   input  wire logic           q_full,
   output logic                q_push,
   output u8vc_entry_type      q_entry
);

   always_comb begin
      req_stall = q_full;
      q_push    = req_valid && !q_full;
      q_entry   = u8vc_classify(req_item);
   end

endmodule
`default_nettype wire

// ----- design/u8vc_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8vc_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module u8vc_fifo
   import u8vc_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepthDefault  // 2 and up
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire u8vc_entry_type wr_data,
   input  wire logic           pop,
   output u8vc_entry_type      rd_data,
   output logic                full,
   output logic                empty
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);

   u8vc_entry_type mem [DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   always_comb begin
      full      = (count_ff == FullCount);
      empty     = (count_ff == '0);
      do_wr     = push && !full;
      do_rd     = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_wr) - CW'(do_rd);
      rd_data  = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FullCount) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ----- design/u8vc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8vc_back
// Text state, mode register and result register. One queued item per clock while no result waits under rsp_stall.
// ----------------------------------------------------------------------------
module u8vc_back
   import u8vc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic           csr_data,
   input  wire logic           q_empty,
   input  wire u8vc_entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output u8vc_rsp_type        rsp_item
);

   logic                  tolerate_ff;
   logic [PendWidth-1:0]  pend_ff, pend_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   u8vc_rsp_type          rsp_item_ff, rsp_item_in;
   logic [PendWidth-1:0]  pend_nx;
   logic [CountWidth-1:0] count_nx;
   logic                  err_nx, bad;

   always_comb begin
      csr_ready = 1'b1;
      q_pop     = !q_empty && (!rsp_valid_ff || !rsp_stall);

      pend_nx  = pend_ff;
      count_nx = count_ff;
      err_nx   = err_ff;
      if (!err_ff) begin
         if (pend_ff != '0) begin
            if (q_entry.cls == CLS_CONT) begin
               pend_nx = pend_ff - PendWidth'(1);
            end else begin
               err_nx = 1'b1;
            end
         end else begin
            case (q_entry.cls)
               CLS_ASCII: begin
                  if (count_ff != CountMax) count_nx = count_ff + CountWidth'(1);
               end
               CLS_LEAD: begin
                  pend_nx = q_entry.pend_load;
                  if (count_ff != CountMax) count_nx = count_ff + CountWidth'(1);
               end
               default: err_nx = 1'b1;
            endcase
         end
      end
      bad = err_nx || ((pend_nx != '0) && !tolerate_ff);

      pend_in      = pend_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (q_pop) begin
         if (q_entry.final_byte) begin
            pend_in      = '0;
            count_in     = '0;
            err_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_item_in.status        = bad;
            rsp_item_in.char_count    = bad ? '0 : count_nx;
            rsp_item_in.missing_bytes = bad ? '0 : pend_nx;
         end else begin
            pend_in  = pend_nx;
            count_in = count_nx;
            err_in   = err_nx;
         end
      end

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerate_ff  <= 1'b0;
         pend_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) tolerate_ff <= csr_data;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status)
         |-> (rsp_item_ff.char_count == '0 && rsp_item_ff.missing_bytes == '0))
      else $error("error item carries a count");

   a_missing_tol: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.final_byte && !tolerate_ff)
         |=> (rsp_item_ff.status || rsp_item_ff.missing_bytes == '0))
      else $error("missing bytes reported in strict mode");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PendWidth'(5))
      else $error("pending continuation count out of range");

   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.final_byte) |=> (pend_ff == '0 && count_ff == '0 && !err_ff))
      else $error("text state not cleared after final item");

endmodule
`default_nettype wire

// ----- design/utf8_validate_and_count_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validate_and_count_top
// UTF-8 validator (original form, up to six bytes) and character counter.
// ----------------------------------------------------------------------------
// Takes one byte per clock when rsp side keeps up; each accepted item is
// classified and queued, and the back end updates the text state one queued
// item per cycle while no result waits under rsp_stall, so the sustained rate
// is one byte per clock, set by that state update. The result of a text passes
// through the queue and then the output register after its final byte is accepted.
// A queue of QUEUE_DEPTH items lets the input keep flowing for that many
// bytes while a result waits to be taken. The mode bit (csr_data) is to be
// written with csr_valid only while the block is idle; the block itself does
// not enforce this. csr_ready is always high.
// ----------------------------------------------------------------------------
module utf8_validate_and_count_top
   import u8vc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire u8vc_req_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output u8vc_rsp_type      rsp_item,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_data
);

   logic           q_push, q_pop, q_full, q_empty;
   u8vc_entry_type q_wr_entry, q_rd_entry;

   u8vc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_wr_entry)
   );

   u8vc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_entry),
      .pop     (q_pop),
      .rd_data (q_rd_entry),
      .full    (q_full),
      .empty   (q_empty)
   );

   u8vc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_empty   (q_empty),
      .q_entry   (q_rd_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
